>>> sv/tpv_pkg.sv
// ----------------------------------------------------------------------------
// tpv_pkg: shared types and constants for the three-axis PID velocity block
// Field widths, payload structs, microcode encoding, the microprogram itself,
// and the saturation helper used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tpv_pkg;

	// field widths and fixed-point formats
	localparam int POS_W     = 32;
	localparam int GAIN_W    = 16;
	localparam int TIME_W    = 16;
	localparam int GAIN_FRAC = 8;
	localparam int TIME_FRAC = 16;
	localparam int CFG_IDX_W = 3;

	// shared multiplier: 33x33 signed covers every product the datapath forms
	localparam int MUL_W  = POS_W + 1;
	localparam int PROD_W = 2 * MUL_W;
	// accumulator for P + I + D before the final clamp
	localparam int ACC_W  = 48;
	// integrator increment after the Q8.8 * Q0.16 rescale
	localparam int INC_W  = 40;

	// derivative divider: |kd*diff| / 2^8 fits 39 bits, three bits per cycle
	localparam int DIVD_W    = 39;
	localparam int DIVS_W    = TIME_W;
	localparam int DIV_BITS  = 3;
	localparam int DIV_ITER  = DIVD_W / DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KP_H = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KI_H = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_KD_H = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_KP_V = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_KI_V = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_KD_V = CFG_IDX_W'(5);

	// axis codes
	typedef logic [1:0] axis_t;
	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	// payload structs
	typedef struct packed {
		logic signed [POS_W-1:0]  goal_x;
		logic signed [POS_W-1:0]  goal_y;
		logic signed [POS_W-1:0]  goal_z;
		logic signed [POS_W-1:0]  meas_x;
		logic signed [POS_W-1:0]  meas_y;
		logic signed [POS_W-1:0]  meas_z;
		logic        [TIME_W-1:0] step_time;
	} in_t;

	typedef struct packed {
		logic signed [POS_W-1:0] vel_x;
		logic signed [POS_W-1:0] vel_y;
		logic signed [POS_W-1:0] vel_z;
		logic                    zero_time_flag;
	} out_t;

	// microcode step addresses
	localparam int NUM_STEPS = 11;
	localparam int STEP_W    = $clog2(NUM_STEPS);
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_IDLE = step_t'(0);
	localparam step_t ST_ERR  = step_t'(1);
	localparam step_t ST_DIFF = step_t'(2);
	localparam step_t ST_P    = step_t'(3);
	localparam step_t ST_KIDT = step_t'(4);
	localparam step_t ST_INT  = step_t'(5);
	localparam step_t ST_ADDI = step_t'(6);
	localparam step_t ST_DIVW = step_t'(7);
	localparam step_t ST_ADDD = step_t'(8);
	localparam step_t ST_OUT  = step_t'(9);
	localparam step_t ST_ZERO = step_t'(10);

	// multiplier operand select
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_KP_ERR,
		MUL_KI_DT,
		MUL_KIDT_ERR,
		MUL_KD_DIFF
	} mul_sel_t;

	// datapath operation
	typedef enum logic [3:0] {
		DP_NOP,
		DP_ERR,
		DP_DIFF,
		DP_P,
		DP_INT,
		DP_ADDI,
		DP_ADDD,
		DP_OUT,
		DP_ZERO
	} dp_op_t;

	// sequencer branch condition
	typedef enum logic [2:0] {
		BR_NEXT,
		BR_WAIT_IN,
		BR_DT_ZERO,
		BR_WAIT_DIV,
		BR_AXIS,
		BR_WAIT_OUT
	} br_t;

	typedef struct packed {
		mul_sel_t mul;
		dp_op_t   op;
		br_t      br;
		step_t    target;
	} ucode_t;

	// microprogram, one control word per step
	localparam ucode_t UCODE [NUM_STEPS] = '{
		'{MUL_NONE,     DP_NOP,  BR_WAIT_IN,  ST_IDLE},  // wait for a transaction
		'{MUL_NONE,     DP_ERR,  BR_DT_ZERO,  ST_ZERO},  // error, skip out on zero dt
		'{MUL_KP_ERR,   DP_DIFF, BR_NEXT,     ST_IDLE},  // err - previous, kp*err
		'{MUL_KI_DT,    DP_P,    BR_NEXT,     ST_IDLE},  // P term, ki*dt
		'{MUL_KIDT_ERR, DP_NOP,  BR_NEXT,     ST_IDLE},  // ki*dt*err
		'{MUL_KD_DIFF,  DP_INT,  BR_NEXT,     ST_IDLE},  // integrator, kd*diff
		'{MUL_NONE,     DP_ADDI, BR_NEXT,     ST_IDLE},  // add I, start divide
		'{MUL_NONE,     DP_NOP,  BR_WAIT_DIV, ST_IDLE},  // wait for quotient
		'{MUL_NONE,     DP_ADDD, BR_AXIS,     ST_ERR},   // add D, next axis
		'{MUL_NONE,     DP_OUT,  BR_WAIT_OUT, ST_IDLE},  // post velocities
		'{MUL_NONE,     DP_ZERO, BR_WAIT_OUT, ST_IDLE}   // post zero-time result
	};

	// clamp an accumulator value to the signed position range
	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
		if (v[ACC_W-1:POS_W-1] == '0 || v[ACC_W-1:POS_W-1] == '1)
			return v[POS_W-1:0];
		return {v[ACC_W-1], {(POS_W-1){~v[ACC_W-1]}}};
	endfunction

endpackage

`default_nettype wire

>>> sv/tpv_div.sv
// ----------------------------------------------------------------------------
// tpv_div: iterative unsigned divider for the derivative term
// Restoring division, a few quotient bits per cycle; done stays high until
// the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module tpv_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [tpv_pkg::DIVD_W-1:0]   dividend,
	input  wire logic [tpv_pkg::DIVS_W-1:0]   divisor,
	output logic                              done,
	output logic [tpv_pkg::DIVD_W-1:0]        quotient
);

	logic [tpv_pkg::DIVD_W-1:0]    quo_q, quo_n;
	logic [tpv_pkg::DIVS_W:0]      rem_q, rem_n;
	logic [tpv_pkg::DIVS_W-1:0]    dsr_q;
	logic [tpv_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          done_q;

	// a few restoring steps per cycle
	always_comb begin
		rem_n = rem_q;
		quo_n = quo_q;
		for (int j = 0; j < tpv_pkg::DIV_BITS; j++) begin
			rem_n = {rem_n[tpv_pkg::DIVS_W-1:0], quo_n[tpv_pkg::DIVD_W-1]};
			quo_n = {quo_n[tpv_pkg::DIVD_W-2:0], 1'b0};
			if (rem_n >= {1'b0, dsr_q}) begin
				rem_n    = rem_n - {1'b0, dsr_q};
				quo_n[0] = 1'b1;
			end
		end
	end

	// iteration count and completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= tpv_pkg::DIV_CNT_W'(tpv_pkg::DIV_ITER);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == tpv_pkg::DIV_CNT_W'(1))
				done_q <= 1'b1;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> sv/three_axis_pid_velocity.sv
// ----------------------------------------------------------------------------
// three_axis_pid_velocity: PID position regulator giving a velocity command
// Microcoded sequencer over one shared multiplier and an iterative divider.
// ----------------------------------------------------------------------------
// Each input transaction carries goal and measured positions for x, y and z
// (signed Q16.16) and the elapsed time (unsigned Q0.16 s); each one yields
// exactly one output transaction with vel = P + I + D per axis, clamped to
// 32 bits, x and y using the horizontal gains and z the vertical gains.
// The integrators and previous errors are cleared by reset. A zero step time
// returns zero velocities with zero_time_flag set and leaves the state alone.
// With a nonzero step time a transaction is worked through axis by axis
// (error, difference, P term, integrator, the radix-8 divide for the
// derivative term, adding D), and the result is then posted; a zero step
// time goes straight to posting. The finished result sits in an output
// register, so a new transaction is accepted while the previous result
// waits. Gains are written through the cfg port (index 0..5, signed Q8.8);
// the user must write them only while the block is idle, as the block
// itself does not enforce it; indexes 6 and 7 are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module three_axis_pid_velocity (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input channel
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire tpv_pkg::in_t                    in_data,
	// output channel
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output tpv_pkg::out_t                        out_data,
	// configuration channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tpv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tpv_pkg::GAIN_W-1:0]      cfg_data
);

	localparam int PW = tpv_pkg::POS_W;
	localparam int GW = tpv_pkg::GAIN_W;
	localparam int MW = tpv_pkg::MUL_W;
	localparam int AW = tpv_pkg::ACC_W;
	localparam int IW = tpv_pkg::INC_W;

	// gain registers
	logic signed [GW-1:0] kp_h_q, ki_h_q, kd_h_q, kp_v_q, ki_v_q, kd_v_q;

	// sequencer
	tpv_pkg::step_t  step_q, step_d;
	tpv_pkg::ucode_t uc;
	tpv_pkg::axis_t  axis_q;

	// datapath registers
	tpv_pkg::in_t                   in_q;
	logic signed [PW-1:0]           err_q;
	logic signed [PW:0]             diff_q;
	logic signed [tpv_pkg::PROD_W-1:0] prod_q;
	logic signed [AW-1:0]           acc_q;
	logic                           neg_q;
	logic signed [PW-1:0]           integ_q [3];
	logic signed [PW-1:0]           prev_q  [3];
	logic signed [PW-1:0]           vel_q   [3];

	// output stage
	logic          out_valid_q;
	tpv_pkg::out_t out_q;

	// combinational helpers
	logic                           in_fire, out_free, load_out;
	logic signed [PW-1:0]           goal_sel, meas_sel;
	logic signed [GW-1:0]           kp_sel, ki_sel, kd_sel;
	logic signed [PW:0]             err_full;
	logic signed [PW-1:0]           err_sat;
	logic signed [MW-1:0]           mul_a, mul_b;
	logic signed [tpv_pkg::PROD_W-1:0] prod_d;
	logic signed [IW-1:0]           inc;
	logic signed [AW-1:0]           integ_sum;
	logic signed [AW-1:0]           kd_prod;
	logic [AW-1:0]                  kd_mag;
	logic                           div_done;
	logic [tpv_pkg::DIVD_W-1:0]     div_quo;
	logic signed [AW-1:0]           d_term;

	assign in_ready  = (step_q == tpv_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign uc        = tpv_pkg::UCODE[step_q];

	// gain register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_h_q <= '0;
			ki_h_q <= '0;
			kd_h_q <= '0;
			kp_v_q <= '0;
			ki_v_q <= '0;
			kd_v_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tpv_pkg::REG_KP_H: kp_h_q <= cfg_data;
				tpv_pkg::REG_KI_H: ki_h_q <= cfg_data;
				tpv_pkg::REG_KD_H: kd_h_q <= cfg_data;
				tpv_pkg::REG_KP_V: kp_v_q <= cfg_data;
				tpv_pkg::REG_KI_V: ki_v_q <= cfg_data;
				tpv_pkg::REG_KD_V: kd_v_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-axis operand select
	always_comb begin
		unique case (axis_q)
			tpv_pkg::AXIS_X: begin
				goal_sel = in_q.goal_x;
				meas_sel = in_q.meas_x;
				kp_sel   = kp_h_q;
				ki_sel   = ki_h_q;
				kd_sel   = kd_h_q;
			end
			tpv_pkg::AXIS_Y: begin
				goal_sel = in_q.goal_y;
				meas_sel = in_q.meas_y;
				kp_sel   = kp_h_q;
				ki_sel   = ki_h_q;
				kd_sel   = kd_h_q;
			end
			default: begin
				goal_sel = in_q.goal_z;
				meas_sel = in_q.meas_z;
				kp_sel   = kp_v_q;
				ki_sel   = ki_v_q;
				kd_sel   = kd_v_q;
			end
		endcase
	end

	// saturated position error
	always_comb begin
		err_full = {goal_sel[PW-1], goal_sel} - {meas_sel[PW-1], meas_sel};
		if (err_full[PW] != err_full[PW-1])
			err_sat = {err_full[PW], {(PW-1){~err_full[PW]}}};
		else
			err_sat = err_full[PW-1:0];
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (uc.mul)
			tpv_pkg::MUL_KP_ERR: begin
				mul_a = {{(MW-GW){kp_sel[GW-1]}}, kp_sel};
				mul_b = {{(MW-PW){err_q[PW-1]}}, err_q};
			end
			tpv_pkg::MUL_KI_DT: begin
				mul_a = {{(MW-GW){ki_sel[GW-1]}}, ki_sel};
				mul_b = {{(MW-tpv_pkg::TIME_W){1'b0}}, in_q.step_time};
			end
			tpv_pkg::MUL_KIDT_ERR: begin
				mul_a = prod_q[MW-1:0];
				mul_b = {{(MW-PW){err_q[PW-1]}}, err_q};
			end
			tpv_pkg::MUL_KD_DIFF: begin
				mul_a = {{(MW-GW){kd_sel[GW-1]}}, kd_sel};
				mul_b = diff_q;
			end
			default: ;
		endcase
		prod_d = mul_a * mul_b;
	end

	// integrator update and derivative magnitude
	always_comb begin
		inc       = prod_q[tpv_pkg::GAIN_FRAC + tpv_pkg::TIME_FRAC +: IW];
		integ_sum = {{(AW-PW){integ_q[axis_q][PW-1]}}, integ_q[axis_q]}
		          + {{(AW-IW){inc[IW-1]}}, inc};
		kd_prod   = prod_q[AW-1:0];
		kd_mag    = kd_prod[AW-1] ? AW'(-kd_prod) : kd_prod;
		d_term    = neg_q ? -{{(AW-tpv_pkg::DIVD_W){1'b0}}, div_quo}
		                  :  {{(AW-tpv_pkg::DIVD_W){1'b0}}, div_quo};
	end

	tpv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (uc.op == tpv_pkg::DP_ADDI),
		.dividend (kd_mag[tpv_pkg::GAIN_FRAC +: tpv_pkg::DIVD_W]),
		.divisor  (in_q.step_time),
		.done     (div_done),
		.quotient (div_quo)
	);

	// next step
	always_comb begin
		unique case (uc.br)
			tpv_pkg::BR_NEXT:     step_d = step_q + 1'b1;
			tpv_pkg::BR_WAIT_IN:  step_d = in_fire ? step_q + 1'b1 : step_q;
			tpv_pkg::BR_DT_ZERO:
				step_d = (in_q.step_time == '0) ? uc.target : step_q + 1'b1;
			tpv_pkg::BR_WAIT_DIV: step_d = div_done ? step_q + 1'b1 : step_q;
			tpv_pkg::BR_AXIS:
				step_d = (axis_q == tpv_pkg::AXIS_Z) ? step_q + 1'b1 : uc.target;
			tpv_pkg::BR_WAIT_OUT: step_d = out_free ? uc.target : step_q;
			default:              step_d = tpv_pkg::ST_IDLE;
		endcase
	end

	assign load_out = (uc.op == tpv_pkg::DP_OUT || uc.op == tpv_pkg::DP_ZERO) && out_free;

	// step counter, axis counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= tpv_pkg::ST_IDLE;
			axis_q      <= tpv_pkg::AXIS_X;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (in_fire)
				axis_q <= tpv_pkg::AXIS_X;
			else if (uc.br == tpv_pkg::BR_AXIS && axis_q != tpv_pkg::AXIS_Z)
				axis_q <= axis_q + 1'b1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// controller state: integrators and previous errors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				integ_q[i] <= '0;
				prev_q[i]  <= '0;
			end
		end else begin
			if (uc.op == tpv_pkg::DP_INT)
				integ_q[axis_q] <= tpv_pkg::sat_pos(integ_sum);
			if (uc.op == tpv_pkg::DP_ADDI)
				prev_q[axis_q] <= err_q;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire)
			in_q <= in_data;
		if (uc.mul != tpv_pkg::MUL_NONE)
			prod_q <= prod_d;
		unique case (uc.op)
			tpv_pkg::DP_ERR:  err_q <= err_sat;
			tpv_pkg::DP_DIFF:
				diff_q <= {err_q[PW-1], err_q} - {prev_q[axis_q][PW-1], prev_q[axis_q]};
			tpv_pkg::DP_P:    acc_q <= prod_q[tpv_pkg::GAIN_FRAC +: AW];
			tpv_pkg::DP_ADDI: begin
				acc_q <= acc_q + {{(AW-PW){integ_q[axis_q][PW-1]}}, integ_q[axis_q]};
				neg_q <= kd_prod[AW-1];
			end
			tpv_pkg::DP_ADDD: vel_q[axis_q] <= tpv_pkg::sat_pos(acc_q + d_term);
			default: ;
		endcase
		if (load_out) begin
			if (uc.op == tpv_pkg::DP_OUT) begin
				out_q.vel_x          <= vel_q[0];
				out_q.vel_y          <= vel_q[1];
				out_q.vel_z          <= vel_q[2];
				out_q.zero_time_flag <= 1'b0;
			end else begin
				out_q.vel_x          <= '0;
				out_q.vel_y          <= '0;
				out_q.vel_z          <= '0;
				out_q.zero_time_flag <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// axis counter never leaves x..z
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		axis_q <= tpv_pkg::AXIS_Z)
		else $error("axis counter out of range");

	// a result only appears after the posting steps
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |->
		$past(step_q == tpv_pkg::ST_OUT || step_q == tpv_pkg::ST_ZERO))
		else $error("output loaded outside a posting step");

	// zero-time results carry zero velocities
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.zero_time_flag) |->
		(out_q.vel_x == '0 && out_q.vel_y == '0 && out_q.vel_z == '0))
		else $error("zero-time result with nonzero velocity");

	// divider is never still finished when a divide step begins waiting
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == tpv_pkg::ST_ADDI) |=> (step_q == tpv_pkg::ST_DIVW && !div_done))
		else $error("divider done flag not cleared by start");

endmodule

`default_nettype wire
